// File: src/masked_byte_pattern_scan_macros.svh
// Assertion macros for the masked byte pattern scan.
// Used by the scan core and the result queue; no other dependencies.
`ifndef MASKED_BYTE_PATTERN_SCAN_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCAN_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MBPS_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MBPS_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MBPS_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define MBPS_ASSERT_NXT(lbl, ck, rs, ante, cons, msg)
`endif

`endif

// File: src/mbps_pkg.sv
// Shared constants and types for the masked byte pattern scan.
// No dependencies; every other source file except the macro header imports this package.
`default_nettype none

package mbps_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int REG_BYTES   = 16;
  // usable pattern length: bounded by the window and by the register bytes
  localparam int EFF_MAX     = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
  localparam int LEN_W       = $clog2(EFF_MAX + 1);
  localparam int IDX_W       = $clog2(EFF_MAX);
  localparam int ADDR_W      = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_CARE_MASK      = 3'd2,
    REG_PATTERN_LENGTH = 3'd3,
    REG_REGION_BASE    = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [EFF_MAX-1:0][7:0] pattern;
    logic [EFF_MAX-1:0]      care;
    logic [LEN_W-1:0]        len;    // already clamped to 1..EFF_MAX
    logic [ADDR_W-1:0]       base;
  } cfg_t;

  typedef struct packed {
    logic              push;
    logic              found;
    logic [ADDR_W-1:0] addr;
  } res_t;

endpackage

`default_nettype wire

// File: src/mbps_if.sv
// Handshake channel interfaces: byte input, result output, register writes.
// Depends on mbps_pkg for widths.
`default_nettype none

interface mbps_byte_if import mbps_pkg::*; ;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface mbps_result_if import mbps_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              found;
  logic [ADDR_W-1:0] match_address;
  modport source (output valid, found, match_address, input ready);
  modport sink   (input valid, found, match_address, output ready);
endinterface

interface mbps_cfg_if import mbps_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/masked_byte_pattern_scan.sv
// Masked byte pattern scan, top level.
// Byte channel byte_in (data_byte, last_byte) feeds one byte per beat. The
// block looks for the first occurrence of a pattern of up to 16 bytes; bytes
// whose care bit is clear are wildcards, pattern byte 0 always compares.
// Channel result_out carries one beat per region: found=1 with the absolute
// start address (region_base plus offset) when the first match completes, or
// found=0 with address 0 at the region's last byte. Bytes after a match are
// dropped until last_byte. Channel cfg writes pattern_low (0), pattern_high
// (1), care_mask (2), pattern_length (3), region_base (4); it is always ready
// and writes belong only in idle periods.
// Throughput: one byte per cycle while the output queue has room; byte_in stalls when it is full.
// The result beat is registered into the output queue (head or skid) as its byte is accepted.
// Results sit in a two-entry output queue; byte_in stays ready while the sink
// stalls until both entries are full.
// Reset (rst, synchronous) restores register defaults, empties the queue and
// starts a fresh region.
// Depends on mbps_pkg, the channel interfaces and the submodules.
`default_nettype none

module masked_byte_pattern_scan import mbps_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  mbps_byte_if.sink     byte_in,
  mbps_cfg_if.sink      cfg,
  mbps_result_if.source result_out
);

  cfg_t regs;
  res_t res;
  logic can_push;
  logic take;

  assign byte_in.ready = can_push;
  assign take          = byte_in.valid && byte_in.ready;

  mbps_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  mbps_scan_core u_scan_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .take      (take),
    .data_byte (byte_in.data_byte),
    .last_byte (byte_in.last_byte),
    .res       (res)
  );

  mbps_result_queue u_result_queue (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .can_push   (can_push),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

// File: src/mbps_cfg_regs.sv
// Configuration register file; clamps pattern_length on write.
// Depends on mbps_pkg and mbps_cfg_if.
`default_nettype none

module mbps_cfg_regs import mbps_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  mbps_cfg_if.sink   cfg,
  output cfg_t       regs
);

  logic       wr;
  logic [4:0] len_raw;
  logic [LEN_W-1:0] len_clamped;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;
  assign len_raw   = cfg.data[4:0];

  always_comb begin
    if (len_raw == 5'd0) begin
      len_clamped = LEN_W'(1);
    end else if (len_raw > 5'(EFF_MAX)) begin
      len_clamped = LEN_W'(EFF_MAX);
    end else begin
      len_clamped = LEN_W'(len_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pattern <= '0;
      regs.care    <= '1;
      regs.len     <= LEN_W'(1);
      regs.base    <= '0;
    end else if (wr) begin
      unique case (cfg.index)
        REG_PATTERN_LOW: begin
          for (int b = 0; b < EFF_MAX; b++) begin
            if (b < 8) regs.pattern[b] <= cfg.data[8*(b & 7) +: 8];
          end
        end
        REG_PATTERN_HIGH: begin
          for (int b = 0; b < EFF_MAX; b++) begin
            if (b >= 8) regs.pattern[b] <= cfg.data[8*(b & 7) +: 8];
          end
        end
        REG_CARE_MASK:      regs.care <= cfg.data[EFF_MAX-1:0];
        REG_PATTERN_LENGTH: regs.len  <= len_clamped;
        REG_REGION_BASE:    regs.base <= cfg.data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/mbps_scan_core.sv
// Sliding byte window, byte counter and masked window compare.
// Depends on mbps_pkg and the assertion macro header.
`default_nettype none
`include "masked_byte_pattern_scan_macros.svh"

module mbps_scan_core import mbps_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       take,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output res_t            res
);

  // newest byte at index 0
  logic [EFF_MAX-1:0][7:0] win;
  logic [EFF_MAX-1:0][7:0] win_next;
  logic [ADDR_W-1:0]       count;
  logic [ADDR_W-1:0]       count_next;
  logic                    reported;
  logic [ADDR_W-1:0]       len_ext;
  logic                    mismatch;
  logic                    hit;
  logic [ADDR_W-1:0]       addr;

  assign len_ext = ADDR_W'(cfg.len);

  always_comb begin
    win_next[0] = data_byte;
    for (int j = 1; j < EFF_MAX; j++) begin
      win_next[j] = win[j-1];
    end
  end

  assign count_next = (count == '1) ? count : count + 1'b1;

  // window slot j holds pattern byte len-1-j; byte 0 always compared
  always_comb begin
    logic [IDX_W-1:0] idx;
    mismatch = 1'b0;
    for (int j = 0; j < EFF_MAX; j++) begin
      idx = IDX_W'(int'(cfg.len) - 1 - j);
      if (j < int'(cfg.len)) begin
        if ((idx == '0 || cfg.care[idx]) && win_next[j] != cfg.pattern[idx]) begin
          mismatch = 1'b1;
        end
      end
    end
  end

  assign hit  = (count_next >= len_ext) && !mismatch;
  assign addr = cfg.base + count_next - len_ext;

  always_comb begin
    res.push  = take && !reported && (hit || last_byte);
    res.found = hit;
    res.addr  = hit ? addr : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      reported <= 1'b0;
    end else if (take) begin
      if (last_byte) begin
        count    <= '0;
        reported <= 1'b0;
      end else if (!reported) begin
        count    <= count_next;
        reported <= hit;
      end
    end
  end

  // stale slots are never compared: the count restarts at zero per region
  always_ff @(posedge clk) begin
    if (take && !reported) begin
      win <= win_next;
    end
  end

  `MBPS_ASSERT_NXT(a_found_latches, clk, rst, res.push && res.found && !last_byte, reported, "match not latched")
  `MBPS_ASSERT_NXT(a_region_restart, clk, rst, take && last_byte, count == '0 && !reported, "region end did not clear scan state")
  `MBPS_ASSERT_IMP(a_silent_after_match, clk, rst, reported, !res.push, "result after match already reported")

endmodule

`default_nettype wire

// File: src/mbps_result_queue.sv
// Two-entry output queue (head register plus skid) for scan results.
// Depends on mbps_pkg, mbps_result_if and the assertion macro header.
`default_nettype none
`include "masked_byte_pattern_scan_macros.svh"

module mbps_result_queue import mbps_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire res_t     res,
  output logic          can_push,
  mbps_result_if.source result_out
);

  logic              head_valid;
  logic              head_found;
  logic [ADDR_W-1:0] head_addr;
  logic              skid_valid;
  logic              skid_found;
  logic [ADDR_W-1:0] skid_addr;
  logic              pop;

  assign can_push                 = !skid_valid;
  assign pop                      = head_valid && result_out.ready;
  assign result_out.valid         = head_valid;
  assign result_out.found         = head_found;
  assign result_out.match_address = head_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        head_valid <= res.push;
      end
    end else if (res.push) begin
      if (head_valid) begin
        skid_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      head_found <= skid_found;
      head_addr  <= skid_addr;
    end else if (res.push && (pop || !head_valid)) begin
      head_found <= res.found;
      head_addr  <= res.addr;
    end
    if (res.push && head_valid && !pop) begin
      skid_found <= res.found;
      skid_addr  <= res.addr;
    end
  end

  `MBPS_ASSERT_IMP(a_skid_needs_head, clk, rst, skid_valid, head_valid, "skid holds a beat with head empty")
  `MBPS_ASSERT_IMP(a_no_push_when_full, clk, rst, res.push, !skid_valid, "result pushed into full queue")
  `MBPS_ASSERT_NXT(a_skid_drains, clk, rst, pop && skid_valid, head_valid && !skid_valid, "skid beat lost on pop")

endmodule

`default_nettype wire
